// ===== rtl/rmnc_pkg.sv =====
`timescale 1ns / 1ps

package rmnc_pkg;

	localparam int PALETTE_SIZE = 14;
	localparam int IDX_W = 4;

	localparam logic [1:0] CH_L = 2'd0;
	localparam logic [1:0] CH_A = 2'd1;
	localparam logic [1:0] CH_B = 2'd2;

	localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(PALETTE_SIZE - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIFF,
		ST_SQR,
		ST_ACC,
		ST_CMP,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic             diff_en;
		logic             sqr_en;
		logic             acc_en;
		logic             acc_first;
		logic             cmp_en;
		logic             cmp_first;
		logic [IDX_W-1:0] entry;
		logic [1:0]       chan;
	} ctrl_t;

	// Palette colors in Lab order L, a, b.
	function automatic logic [23:0] palette_color(input logic [IDX_W-1:0] idx);
		logic [23:0] c;
		case (idx)
			4'd0:    c = {8'd1,   8'd128, 8'd128};
			4'd1:    c = {8'd224, 8'd117, 8'd114};
			4'd2:    c = {8'd82,  8'd207, 8'd20};
			4'd3:    c = {8'd83,  8'd144, 8'd163};
			4'd4:    c = {8'd115, 8'd135, 8'd152};
			4'd5:    c = {8'd223, 8'd42,  8'd211};
			4'd6:    c = {8'd112, 8'd84,  8'd159};
			4'd7:    c = {8'd156, 8'd186, 8'd199};
			4'd8:    c = {8'd179, 8'd159, 8'd129};
			4'd9:    c = {8'd139, 8'd213, 8'd119};
			4'd10:   c = {8'd119, 8'd200, 8'd184};
			4'd11:   c = {8'd90,  8'd184, 8'd152};
			4'd12:   c = {8'd255, 8'd128, 8'd128};
			4'd13:   c = {8'd255, 8'd128, 8'd255};
			default: c = 24'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] palette_chan(input logic [IDX_W-1:0] idx,
		input logic [1:0] ch);
		logic [23:0] c;
		logic [7:0]  v;
		c = palette_color(idx);
		case (ch)
			CH_L:    v = c[23:16];
			CH_A:    v = c[15:8];
			CH_B:    v = c[7:0];
			default: v = 8'd0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/rmnc_accum.sv =====
`timescale 1ns / 1ps

module rmnc_accum #(
	parameter int MAX_PIXELS = 1048576,
	parameter int CW = 21,
	parameter int SW = 29
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          add_en,
	input  logic          clear,
	input  logic [7:0]    l_value,
	input  logic [7:0]    a_value,
	input  logic [7:0]    b_value,
	output logic [CW-1:0] count,
	output logic [SW-1:0] sum_l,
	output logic [SW-1:0] sum_a,
	output logic [SW-1:0] sum_b
);

	logic [CW-1:0] count_q;
	logic [SW-1:0] sum_l_q;
	logic [SW-1:0] sum_a_q;
	logic [SW-1:0] sum_b_q;
	logic          room;

	assign room = count_q < CW'(MAX_PIXELS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_l_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (clear) begin
			count_q <= '0;
			sum_l_q <= '0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else if (add_en && room) begin
			count_q <= count_q + 1'b1;
			sum_l_q <= sum_l_q + SW'(l_value);
			sum_a_q <= sum_a_q + SW'(a_value);
			sum_b_q <= sum_b_q + SW'(b_value);
		end
	end

	assign count = count_q;
	assign sum_l = sum_l_q;
	assign sum_a = sum_a_q;
	assign sum_b = sum_b_q;

endmodule

// ===== rtl/rmnc_seq.sv =====
`timescale 1ns / 1ps

module rmnc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            out_free,
	output rmnc_pkg::ctrl_t ctrl,
	output logic            busy,
	output logic            load_out,
	output logic            clear_acc
);

	import rmnc_pkg::*;

	seq_state_t       state_q;
	seq_state_t       state_d;
	logic [IDX_W-1:0] entry_q;
	logic [1:0]       chan_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DIFF;
			end
			ST_DIFF: state_d = ST_SQR;
			ST_SQR:  state_d = ST_ACC;
			ST_ACC: begin
				state_d = (chan_q == CH_B) ? ST_CMP : ST_DIFF;
			end
			ST_CMP: begin
				state_d = (entry_q == LAST_ENTRY) ? ST_DONE : ST_DIFF;
			end
			ST_DONE: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			entry_q <= '0;
			chan_q  <= CH_L;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					entry_q <= '0;
					chan_q  <= CH_L;
				end
				ST_ACC: begin
					if (chan_q != CH_B) chan_q <= chan_q + 2'd1;
				end
				ST_CMP: begin
					chan_q  <= CH_L;
					entry_q <= entry_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		ctrl           = '0;
		ctrl.entry     = entry_q;
		ctrl.chan      = chan_q;
		ctrl.acc_first = chan_q == CH_L;
		ctrl.cmp_first = entry_q == '0;
		load_out       = 1'b0;
		clear_acc      = 1'b0;
		case (state_q)
			ST_DIFF: ctrl.diff_en = 1'b1;
			ST_SQR:  ctrl.sqr_en = 1'b1;
			ST_ACC:  ctrl.acc_en = 1'b1;
			ST_CMP:  ctrl.cmp_en = 1'b1;
			ST_DONE: begin
				load_out  = out_free;
				clear_acc = out_free;
			end
			default: ;
		endcase
	end

	assign busy = state_q != ST_IDLE;

endmodule

// ===== rtl/rmnc_dist.sv =====
`timescale 1ns / 1ps

module rmnc_dist #(
	parameter int CW = 21,
	parameter int SW = 29
) (
	input  logic                        clk,
	input  rmnc_pkg::ctrl_t             ctrl,
	input  logic [CW-1:0]               count,
	input  logic [SW-1:0]               sum_l,
	input  logic [SW-1:0]               sum_a,
	input  logic [SW-1:0]               sum_b,
	output logic [rmnc_pkg::IDX_W-1:0]  best_idx
);

	import rmnc_pkg::*;

	localparam int DW = (CW + 8 > SW) ? CW + 8 : SW;
	localparam int QW = 2 * DW;
	localparam int AW = QW + 2;

	logic [7:0]       pal;
	logic [SW-1:0]    sum_sel;
	logic [DW-1:0]    prod;
	logic [DW-1:0]    sum_ext;
	logic [DW-1:0]    diff_q;
	logic [QW-1:0]    sq_q;
	logic [AW-1:0]    dist_q;
	logic [AW-1:0]    best_q;
	logic [IDX_W-1:0] best_idx_q;

	assign pal = palette_chan(ctrl.entry, ctrl.chan);

	always_comb begin
		case (ctrl.chan)
			CH_L:    sum_sel = sum_l;
			CH_A:    sum_sel = sum_a;
			CH_B:    sum_sel = sum_b;
			default: sum_sel = '0;
		endcase
	end

	assign prod    = DW'(count) * DW'(pal);
	assign sum_ext = DW'(sum_sel);

	always_ff @(posedge clk) begin
		if (ctrl.diff_en) begin
			diff_q <= (prod >= sum_ext) ? prod - sum_ext : sum_ext - prod;
		end
		if (ctrl.sqr_en) begin
			sq_q <= QW'(diff_q) * QW'(diff_q);
		end
		if (ctrl.acc_en) begin
			dist_q <= ctrl.acc_first ? AW'(sq_q) : dist_q + AW'(sq_q);
		end
		if (ctrl.cmp_en && (ctrl.cmp_first || dist_q < best_q)) begin
			best_q     <= dist_q;
			best_idx_q <= ctrl.entry;
		end
	end

	assign best_idx = best_idx_q;

endmodule

// ===== rtl/region_mean_nearest_color.sv =====
`timescale 1ns / 1ps

// Classifies the mean Lab color of a pixel region against a fixed palette of 14 colors.
// Pixels are accepted one per cycle when not stalled and summed. After the pixel that
// carries last_pixel, the input is stalled while one shared squarer walks the 14 palette
// entries, three channels each; each channel passes through difference, square and
// accumulate steps and each entry ends with a compare. The result then waits while a
// pending output is held by out_stall. The index goes out through a registered output,
// and new pixels are accepted again from the cycle after it is loaded.
module region_mean_nearest_color #(
	parameter int MAX_PIXELS = 1048576
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 l_value,
	input  logic [7:0]                 a_value,
	input  logic [7:0]                 b_value,
	input  logic                       last_pixel,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [rmnc_pkg::IDX_W-1:0] color_index
);

	import rmnc_pkg::*;

	localparam int CW = $clog2(MAX_PIXELS + 1);
	localparam int SW = CW + 8;

	logic             in_take;
	logic             start;
	logic             out_free;
	logic             busy;
	logic             load_out;
	logic             clear_acc;
	ctrl_t            ctrl;
	logic [CW-1:0]    count;
	logic [SW-1:0]    sum_l;
	logic [SW-1:0]    sum_a;
	logic [SW-1:0]    sum_b;
	logic [IDX_W-1:0] best_idx;
	logic             out_valid_q;
	logic [IDX_W-1:0] color_index_q;

	assign in_stall = busy;
	assign in_take  = in_valid && !busy;
	assign start    = in_take && last_pixel;
	assign out_free = !out_valid_q || !out_stall;

	rmnc_accum #(
		.MAX_PIXELS(MAX_PIXELS),
		.CW(CW),
		.SW(SW)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.add_en(in_take),
		.clear(clear_acc),
		.l_value(l_value),
		.a_value(a_value),
		.b_value(b_value),
		.count(count),
		.sum_l(sum_l),
		.sum_a(sum_a),
		.sum_b(sum_b)
	);

	rmnc_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.out_free(out_free),
		.ctrl(ctrl),
		.busy(busy),
		.load_out(load_out),
		.clear_acc(clear_acc)
	);

	rmnc_dist #(
		.CW(CW),
		.SW(SW)
	) u_dist (
		.clk(clk),
		.ctrl(ctrl),
		.count(count),
		.sum_l(sum_l),
		.sum_a(sum_a),
		.sum_b(sum_b),
		.best_idx(best_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) color_index_q <= best_idx;
	end

	assign out_valid   = out_valid_q;
	assign color_index = color_index_q;

`ifndef SYNTHESIS
	// A last pixel starts the palette search, so the input stalls on the next cycle.
	a_start_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && last_pixel) |=> in_stall)
		else $error("input not stalled after last pixel");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (color_index < IDX_W'(PALETTE_SIZE)))
		else $error("color index out of palette range");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= CW'(MAX_PIXELS))
		else $error("pixel count beyond limit");

	// A new result is loaded only into a free output register.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (!out_valid || !out_stall))
		else $error("pending result overwritten");
`endif

endmodule
